/* rtl/u8e_pkg.sv */
// ----------------------------------------------------------------------------
// u8e_pkg
// Shared types and constants for the six-byte UTF-8 encoder.
// ----------------------------------------------------------------------------
package u8e_pkg;

    localparam int CP_W    = 32;
    localparam int COUNT_W = 16;
    localparam int BYTE_W  = 8;
    localparam int MAX_LEN = 6;
    localparam int LEN_W   = 3;

    localparam logic [COUNT_W-1:0] CAPACITY_RESET = 16'hffff;

    localparam logic [CP_W-1:0] LIMIT_1 = 32'h0000_007f;
    localparam logic [CP_W-1:0] LIMIT_2 = 32'h0000_07ff;
    localparam logic [CP_W-1:0] LIMIT_3 = 32'h0000_ffff;
    localparam logic [CP_W-1:0] LIMIT_4 = 32'h001f_ffff;
    localparam logic [CP_W-1:0] LIMIT_5 = 32'h03ff_ffff;
    localparam logic [CP_W-1:0] LIMIT_6 = 32'h7fff_ffff;

    localparam logic [1:0] CONT_MARK = 2'b10;

    // one encoded item, lead byte in slot 0
    typedef struct packed {
        logic [MAX_LEN-1:0][BYTE_W-1:0] bytes;
        logic [LEN_W-1:0]               len;
        logic                           byte_valid;
        logic                           refused;
        logic                           done_res;
        logic [COUNT_W-1:0]             first_total;
    } enc_t;

endpackage

/* rtl/u8e_if.sv */
// ----------------------------------------------------------------------------
// u8e_cp_if / u8e_byte_if
// Valid/ready channels for code points in and UTF-8 bytes out.
// ----------------------------------------------------------------------------
interface u8e_cp_if
    import u8e_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [CP_W-1:0] code_point;
    logic            string_start;

    modport source (output valid, output code_point, output string_start, input ready);
    modport sink (input valid, input code_point, input string_start, output ready);
endinterface

interface u8e_byte_if
    import u8e_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [BYTE_W-1:0]  out_byte;
    logic               byte_valid;
    logic               last;
    logic               refused;
    logic               done_res;
    logic [COUNT_W-1:0] bytes_total;

    modport source (
        output valid, output out_byte, output byte_valid, output last,
        output refused, output done_res, output bytes_total, input ready
    );
    modport sink (
        input valid, input out_byte, input byte_valid, input last,
        input refused, input done_res, input bytes_total, output ready
    );
endinterface

/* rtl/u8e_in_stage.sv */
// ----------------------------------------------------------------------------
// u8e_in_stage
// Input register; holds one code point until the serializer can take it.
// ----------------------------------------------------------------------------
module u8e_in_stage
    import u8e_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    u8e_cp_if.sink          in_ch,
    input  logic            take,
    output logic            held,
    output logic [CP_W-1:0] code_point,
    output logic            string_start
);

    logic            valid_reg;
    logic            valid_next;
    logic [CP_W-1:0] cp_reg;
    logic            start_reg;
    logic            load;

    assign in_ch.ready  = !valid_reg || take;
    assign load         = in_ch.valid && in_ch.ready;
    assign valid_next   = load || (valid_reg && !take);
    assign held         = valid_reg;
    assign code_point   = cp_reg;
    assign string_start = start_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cp_reg    <= in_ch.code_point;
            start_reg <= in_ch.string_start;
        end
    end

endmodule

/* rtl/u8e_encode.sv */
// ----------------------------------------------------------------------------
// u8e_encode
// Length select, byte build and capacity check for one code point.
// ----------------------------------------------------------------------------
module u8e_encode
    import u8e_pkg::*;
(
    input  logic [CP_W-1:0]    code_point,
    input  logic               string_start,
    input  logic [COUNT_W-1:0] byte_count,
    input  logic               stopped,
    input  logic [COUNT_W-1:0] capacity,
    output enc_t               enc,
    output logic [COUNT_W-1:0] count_next,
    output logic               stopped_next
);

    logic [COUNT_W-1:0]             count_eff;
    logic                           stopped_eff;
    logic [LEN_W-1:0]               len;
    logic [BYTE_W-1:0]              lead;
    logic [MAX_LEN-1:0][5:0]        groups;
    logic [MAX_LEN-1:0][BYTE_W-1:0] slots;
    logic [LEN_W-1:0]               idx;
    logic [COUNT_W:0]               sum;
    logic                           is_zero;
    logic                           over;

    assign count_eff   = string_start ? '0 : byte_count;
    assign stopped_eff = string_start ? 1'b0 : stopped;
    assign is_zero     = (code_point == '0);

    always_comb
    begin
        priority if (code_point <= LIMIT_1) len = 3'd1;
        else if (code_point <= LIMIT_2)     len = 3'd2;
        else if (code_point <= LIMIT_3)     len = 3'd3;
        else if (code_point <= LIMIT_4)     len = 3'd4;
        else if (code_point <= LIMIT_5)     len = 3'd5;
        else if (code_point <= LIMIT_6)     len = 3'd6;
        else                                len = 3'd1;
    end

    always_comb
    begin
        unique case (len)
            3'd2:    lead = {3'b110, code_point[10:6]};
            3'd3:    lead = {4'b1110, code_point[15:12]};
            3'd4:    lead = {5'b11110, code_point[20:18]};
            3'd5:    lead = {6'b111110, code_point[25:24]};
            3'd6:    lead = {7'b1111110, code_point[30]};
            default: lead = {1'b0, code_point[6:0]};
        endcase
    end

    // six-bit groups, lowest first
    always_comb
    begin
        groups[0] = code_point[5:0];
        groups[1] = code_point[11:6];
        groups[2] = code_point[17:12];
        groups[3] = code_point[23:18];
        groups[4] = code_point[29:24];
        groups[5] = {4'b0000, code_point[31:30]};
    end

    always_comb
    begin
        idx = '0;
        for (int k = 0; k < MAX_LEN; k++)
        begin
            idx      = len - LEN_W'(k) - LEN_W'(1);
            slots[k] = (LEN_W'(k) < len) ? {CONT_MARK, groups[idx]} : '0;
        end
        slots[0] = lead;
    end

    assign sum  = {1'b0, count_eff} + {{(COUNT_W+1-LEN_W){1'b0}}, len};
    assign over = stopped_eff || (sum > {1'b0, capacity});

    always_comb
    begin
        enc.bytes       = '0;
        enc.len         = 3'd1;
        enc.byte_valid  = 1'b0;
        enc.refused     = 1'b0;
        enc.done_res    = 1'b0;
        enc.first_total = count_eff;
        count_next      = count_eff;
        stopped_next    = stopped_eff;
        if (is_zero)
        begin
            enc.done_res = 1'b1;
        end
        else if (over)
        begin
            enc.refused  = 1'b1;
            stopped_next = 1'b1;
        end
        else
        begin
            enc.bytes       = slots;
            enc.len         = len;
            enc.byte_valid  = 1'b1;
            enc.first_total = count_eff + COUNT_W'(1);
            count_next      = sum[COUNT_W-1:0];
        end
    end

endmodule

/* rtl/u8e_serializer.sv */
// ----------------------------------------------------------------------------
// u8e_serializer
// Result register; shifts one encoded item out a byte per transaction.
// ----------------------------------------------------------------------------
module u8e_serializer
    import u8e_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  enc_t        enc,
    input  logic        load,
    output logic        can_load,
    u8e_byte_if.source  out_ch
);

    logic                           valid_reg;
    logic                           valid_next;
    logic [MAX_LEN-1:0][BYTE_W-1:0] bytes_reg;
    logic [LEN_W-1:0]               left_reg;
    logic [COUNT_W-1:0]             total_reg;
    logic                           byte_valid_reg;
    logic                           refused_reg;
    logic                           done_reg;
    logic                           is_last;
    logic                           pop;

    assign is_last  = (left_reg == LEN_W'(1));
    assign pop      = valid_reg && out_ch.ready;
    assign can_load = !valid_reg || (out_ch.ready && is_last);

    assign valid_next = load || (valid_reg && !(pop && is_last));

    assign out_ch.valid       = valid_reg;
    assign out_ch.out_byte    = bytes_reg[0];
    assign out_ch.byte_valid  = byte_valid_reg;
    assign out_ch.last        = is_last;
    assign out_ch.refused     = refused_reg;
    assign out_ch.done_res    = done_reg;
    assign out_ch.bytes_total = total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            left_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (load)
            begin
                left_reg <= enc.len;
            end
            else if (pop)
            begin
                left_reg <= left_reg - LEN_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bytes_reg      <= enc.bytes;
            total_reg      <= enc.first_total;
            byte_valid_reg <= enc.byte_valid;
            refused_reg    <= enc.refused;
            done_reg       <= enc.done_res;
        end
        else if (pop)
        begin
            bytes_reg <= {{BYTE_W{1'b0}}, bytes_reg[MAX_LEN-1:1]};
            total_reg <= total_reg + COUNT_W'(1);
        end
    end

endmodule

/* rtl/utf8_encoder.sv */
// ----------------------------------------------------------------------------
// utf8_encoder
// Streams wide code points into 1 to 6 byte UTF-8, one byte per transaction,
// with a per-string byte count checked against a configured capacity.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  in_ch     in   valid/ready   code_point, string_start
//  out_ch    out  valid/ready   out_byte, byte_valid, last, refused,
//                               done_res, bytes_total
//  cfg       in   cfg_wr_en     cfg_wr_data (output_capacity)
//
// An item passes through the input register, then leaves the result register
// one byte per cycle while out_ch is ready: a transaction per byte, one for a
// refusal or a terminator, so the serializer's byte rate sets throughput.
// A new item is taken while the last byte of the previous one is shown.
// Stalls on out_ch back up into the input register, then into in_ch.
// Reset clears the count, the refusal flag and sets the capacity to 65535.
// ----------------------------------------------------------------------------
module utf8_encoder
    import u8e_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    u8e_cp_if.sink             in_ch,
    u8e_byte_if.source         out_ch,
    input  logic               cfg_wr_en,
    input  logic [COUNT_W-1:0] cfg_wr_data
);

    logic [COUNT_W-1:0] capacity_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               stopped_reg;
    logic               stopped_next;
    logic               held;
    logic               can_load;
    logic               take;
    logic [CP_W-1:0]    code_point;
    logic               string_start;
    enc_t               enc;

    assign take = held && can_load;

    u8e_in_stage u_in_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ch        (in_ch),
        .take         (take),
        .held         (held),
        .code_point   (code_point),
        .string_start (string_start)
    );

    u8e_encode u_encode (
        .code_point   (code_point),
        .string_start (string_start),
        .byte_count   (count_reg),
        .stopped      (stopped_reg),
        .capacity     (capacity_reg),
        .enc          (enc),
        .count_next   (count_next),
        .stopped_next (stopped_next)
    );

    u8e_serializer u_serializer (
        .clk      (clk),
        .rst_n    (rst_n),
        .enc      (enc),
        .load     (take),
        .can_load (can_load),
        .out_ch   (out_ch)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
            count_reg    <= '0;
            stopped_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                capacity_reg <= cfg_wr_data;
            end
            if (take)
            begin
                count_reg   <= count_next;
                stopped_reg <= stopped_next;
            end
        end
    end

endmodule

/* tb/utf8_encoder_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_encoder_test
// Sends code points through the six-byte UTF-8 encoder with random gaps and
// output stalls. Every byte transaction is checked field by field against an
// in-bench encoder that tracks the string byte count and the refusal flag.
// The output capacity is changed between phases, from 0 up to 65535.
// ----------------------------------------------------------------------------
module utf8_encoder_test;
    import u8e_pkg::*;

    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int MAX_REPORTS     = 50;

    localparam logic [BYTE_W-1:0] LEAD_MARK_1 = 8'h00;
    localparam logic [BYTE_W-1:0] LEAD_MARK_2 = 8'hc0;
    localparam logic [BYTE_W-1:0] LEAD_MARK_3 = 8'he0;
    localparam logic [BYTE_W-1:0] LEAD_MARK_4 = 8'hf0;
    localparam logic [BYTE_W-1:0] LEAD_MARK_5 = 8'hf8;
    localparam logic [BYTE_W-1:0] LEAD_MARK_6 = 8'hfc;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic               byte_valid;
        logic               last;
        logic               refused;
        logic               done_res;
        logic [COUNT_W-1:0] bytes_total;
    } byte_result_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [COUNT_W-1:0] cfg_wr_data;

    u8e_cp_if   cp_bus ();
    u8e_byte_if byte_bus ();

    utf8_encoder uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (cp_bus),
        .out_ch      (byte_bus),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    byte_result_t       pending_bytes[$];
    logic [COUNT_W-1:0] capacity_setting;
    logic [COUNT_W-1:0] string_bytes;
    logic               string_refused;

    int mismatches;
    int idle_cycles;
    bit in_gaps_on;
    bit out_stalls_on;
    bit hold_off_req;
    int hold_left;
    int stall_left;

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // expected transaction goes to the tail of the queue
    function automatic void queue_result(byte_result_t res);
        pending_bytes.insert(pending_bytes.size(), res);
    endfunction

    function automatic void encode_code_point(logic [CP_W-1:0] cp, logic start);
        byte_result_t      res;
        logic [CP_W-1:0]   shifted;
        logic [BYTE_W-1:0] lead_mask;
        logic [BYTE_W-1:0] lead_mark;
        int                len;
        if (start)
        begin
            string_bytes   = '0;
            string_refused = 1'b0;
        end
        res = '0;
        if (cp == '0)
        begin
            res.last        = 1'b1;
            res.done_res    = 1'b1;
            res.bytes_total = string_bytes;
            queue_result(res);
            return;
        end
        if (cp <= LIMIT_1)
        begin
            len = 1; lead_mask = 8'h7f; lead_mark = LEAD_MARK_1;
        end
        else if (cp <= LIMIT_2)
        begin
            len = 2; lead_mask = 8'h1f; lead_mark = LEAD_MARK_2;
        end
        else if (cp <= LIMIT_3)
        begin
            len = 3; lead_mask = 8'h0f; lead_mark = LEAD_MARK_3;
        end
        else if (cp <= LIMIT_4)
        begin
            len = 4; lead_mask = 8'h07; lead_mark = LEAD_MARK_4;
        end
        else if (cp <= LIMIT_5)
        begin
            len = 5; lead_mask = 8'h03; lead_mark = LEAD_MARK_5;
        end
        else if (cp <= LIMIT_6)
        begin
            len = 6; lead_mask = 8'h01; lead_mark = LEAD_MARK_6;
        end
        else
        begin
            // above the six-byte range: low 7 bits as a single byte
            len = 1; lead_mask = 8'h7f; lead_mark = LEAD_MARK_1;
        end
        if (string_refused || int'(string_bytes) + len > int'(capacity_setting))
        begin
            string_refused  = 1'b1;
            res.last        = 1'b1;
            res.refused     = 1'b1;
            res.bytes_total = string_bytes;
            queue_result(res);
            return;
        end
        for (int k = 0; k < len; k++)
        begin
            shifted = cp >> (6 * (len - 1 - k));
            res = '0;
            if (k == 0)
                res.out_byte = lead_mark | (shifted[BYTE_W-1:0] & lead_mask);
            else
                res.out_byte = {CONT_MARK, shifted[5:0]};
            string_bytes    = string_bytes + COUNT_W'(1);
            res.byte_valid  = 1'b1;
            res.last        = (k == len - 1);
            res.bytes_total = string_bytes;
            queue_result(res);
        end
    endfunction

    function automatic logic [CP_W-1:0] random_code_point();
        logic [CP_W-1:0] cp;
        case ($urandom_range(0, 9))
            0, 1:    cp = $urandom_range(1, LIMIT_1);
            2, 3:    cp = $urandom_range(LIMIT_1 + 1, LIMIT_2);
            4:       cp = $urandom_range(LIMIT_2 + 1, LIMIT_3);
            5:       cp = $urandom_range(LIMIT_3 + 1, LIMIT_4);
            6:       cp = $urandom_range(LIMIT_4 + 1, LIMIT_5);
            7:       cp = $urandom_range(LIMIT_5 + 1, LIMIT_6);
            8:       cp = 32'h8000_0000 | $urandom;
            default: cp = $urandom;
        endcase
        return cp;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    endtask

    // called at a falling edge, returns at a falling edge with valid left high
    task automatic send_cp(logic [CP_W-1:0] cp, logic start);
        int gap;
        if (in_gaps_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 3);
            cp_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cp_bus.valid        <= 1'b1;
        cp_bus.code_point   <= cp;
        cp_bus.string_start <= start;
        do
            @(posedge clk);
        while (!cp_bus.ready);
        encode_code_point(cp, start);
        @(negedge clk);
    endtask

    task automatic wait_results_drained();
        cp_bus.valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_capacity(logic [COUNT_W-1:0] value);
        wait_results_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        capacity_setting = value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_string(int len);
        bit opening;
        opening = ($urandom_range(0, 5) != 0);
        for (int i = 0; i < len; i++)
            send_cp(random_code_point(), (i == 0) ? opening : ($urandom_range(0, 24) == 0));
        if ($urandom_range(0, 7) != 0)
            send_cp('0, 1'b0);
    endtask

    task automatic test_encoding_ranges();
        send_cp(LIMIT_1, 1'b1);
        send_cp(LIMIT_1 + 1, 1'b0);
        send_cp(LIMIT_2, 1'b0);
        send_cp(LIMIT_2 + 1, 1'b0);
        send_cp(LIMIT_3, 1'b0);
        send_cp(LIMIT_3 + 1, 1'b0);
        send_cp(LIMIT_4, 1'b0);
        send_cp(LIMIT_4 + 1, 1'b0);
        send_cp(LIMIT_5, 1'b0);
        send_cp(LIMIT_5 + 1, 1'b0);
        send_cp(LIMIT_6, 1'b0);
        send_cp(32'h8000_0000, 1'b0);
        send_cp(32'hffff_ffff, 1'b0);
        send_cp('0, 1'b0);
    endtask

    task automatic test_capacity_limits();
        write_capacity(16'd5);
        send_cp(32'h41, 1'b1);
        send_cp(32'h800, 1'b0);
        send_cp(32'h80, 1'b0);
        send_cp(32'h41, 1'b0);
        send_cp('0, 1'b0);
        send_cp(32'h41, 1'b0);
        write_capacity(16'd0);
        send_cp(32'h41, 1'b1);
        send_cp('0, 1'b1);
        // capacity lowered below a count already reached
        write_capacity(CAPACITY_RESET);
        send_cp(32'h800, 1'b1);
        send_cp(32'hffff, 1'b0);
        send_cp(32'h7ff, 1'b0);
        write_capacity(16'd4);
        send_cp(32'h41, 1'b0);
        send_cp('0, 1'b0);
    endtask

    task automatic test_backpressure();
        write_capacity(CAPACITY_RESET);
        in_gaps_on = 1'b0;
        @(posedge clk);
        hold_off_req = 1'b1;
        @(negedge clk);
        send_string(20);
        wait_results_drained();
    endtask

    task automatic test_random_strings();
        logic [COUNT_W-1:0] caps [8];
        int phase_items;
        int len;
        caps = '{CAPACITY_RESET, 16'd20, 16'd1, 16'd0, 16'd300, 16'd12, 16'd40, CAPACITY_RESET};
        caps[6] = $urandom_range(2, 60);
        for (int phase = 0; phase < 8; phase++)
        begin
            write_capacity(caps[phase]);
            in_gaps_on    = (phase < 7) && ($urandom_range(0, 3) != 0);
            out_stalls_on = (phase < 7) && ($urandom_range(0, 3) != 0);
            phase_items = 0;
            while (phase_items < 55)
            begin
                len = $urandom_range(1, 12);
                send_string(len);
                phase_items += len + 1;
            end
        end
        wait_results_drained();
    endtask

    // receiver: random stall bursts plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_off_req)
        begin
            hold_left    = HOLD_OFF_CYCLES;
            hold_off_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            byte_bus.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            byte_bus.ready <= 1'b0;
        end
        else if (out_stalls_on && $urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(0, 2);
            byte_bus.ready <= 1'b0;
        end
        else
            byte_bus.ready <= 1'b1;
    end

    always @(posedge clk)
    begin : check_output
        byte_result_t want;
        if (rst_n && byte_bus.valid && byte_bus.ready)
        begin
            if (pending_bytes.size() == 0)
                report_mismatch("unexpected transaction", byte_bus.out_byte, 0);
            else
            begin
                want = pending_bytes.pop_front();
                if (byte_bus.out_byte !== want.out_byte)
                    report_mismatch("out_byte", byte_bus.out_byte, want.out_byte);
                if (byte_bus.byte_valid !== want.byte_valid)
                    report_mismatch("byte_valid", byte_bus.byte_valid, want.byte_valid);
                if (byte_bus.last !== want.last)
                    report_mismatch("last", byte_bus.last, want.last);
                if (byte_bus.refused !== want.refused)
                    report_mismatch("refused", byte_bus.refused, want.refused);
                if (byte_bus.done_res !== want.done_res)
                    report_mismatch("done_res", byte_bus.done_res, want.done_res);
                if (byte_bus.bytes_total !== want.bytes_total)
                    report_mismatch("bytes_total", byte_bus.bytes_total, want.bytes_total);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cp_bus.valid && cp_bus.ready) || (byte_bus.valid && byte_bus.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_wr_data         = '0;
        cp_bus.valid        = 1'b0;
        cp_bus.code_point   = '0;
        cp_bus.string_start = 1'b0;
        byte_bus.ready      = 1'b0;
        capacity_setting    = CAPACITY_RESET;
        string_bytes        = '0;
        string_refused      = 1'b0;
        mismatches          = 0;
        idle_cycles         = 0;
        hold_off_req        = 1'b0;
        hold_left           = 0;
        stall_left          = 0;
        in_gaps_on          = 1'b1;
        out_stalls_on       = 1'b1;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_encoding_ranges();
        test_capacity_limits();
        test_backpressure();
        test_random_strings();

        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* files.f */
rtl/u8e_pkg.sv
rtl/u8e_if.sv
rtl/u8e_in_stage.sv
rtl/u8e_encode.sv
rtl/u8e_serializer.sv
rtl/utf8_encoder.sv
tb/utf8_encoder_test.sv
